### src/ccp_pkg.sv
`default_nettype none
package ccp_pkg;

  localparam int MaxDigitsDefault = 9;
  localparam int QueueDepth = 2;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] WsMax = 8'd32;
  localparam logic [7:0] ChPlus = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;

  // classified input word handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       ws;
    logic       hex;
    logic       dec;
    logic       plus;
    logic       minus;
    logic [3:0] hex_val;
  } word_t;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'b0001,
    PH_CODE   = 4'b0010,
    PH_PARAM  = 4'b0100,
    PH_REJECT = 4'b1000
  } phase_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      r = r[7] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/ccp_in_if.sv
`default_nettype none
interface ccp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface
`default_nettype wire

### src/ccp_out_if.sv
`default_nettype none
interface ccp_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        command_code;
  logic signed [30:0] param_value;
  logic              param_present;

  modport source (output valid, output command_code, output param_value,
                  output param_present, input ready);
  modport sink (input valid, input command_code, input param_value,
                input param_present, output ready);
endinterface
`default_nettype wire

### src/ccp_front.sv
`default_nettype none
module ccp_front
  import ccp_pkg::*;
(
  ccp_in_if.sink bytes,
  output logic  word_valid,
  input  logic  word_ready,
  output word_t word
);

  logic [7:0] c;
  logic       is_dec;
  logic       is_upper;
  logic       is_lower;

  assign c = bytes.byte_in;
  assign is_dec = (c >= 8'h30) && (c <= 8'h39);
  assign is_upper = (c >= 8'h41) && (c <= 8'h46);
  assign is_lower = (c >= 8'h61) && (c <= 8'h66);

  always_comb begin
    word.ch = c;
    word.ws = (c <= WsMax);
    word.dec = is_dec;
    word.hex = is_dec || is_upper || is_lower;
    word.plus = (c == ChPlus);
    word.minus = (c == ChMinus);
    word.hex_val = is_dec ? c[3:0] : c[3:0] + 4'd9;
  end

  assign word_valid = bytes.valid;
  assign bytes.ready = word_ready;

endmodule
`default_nettype wire

### src/ccp_queue.sv
`default_nettype none
module ccp_queue
  import ccp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  word_t push_word,
  output logic  pop_valid,
  input  logic  pop_ready,
  output word_t pop_word
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  word_t            mem [QueueDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CntW'(QueueDepth));
  assign pop_valid = (count != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_word = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/ccp_back.sv
`default_nettype none
module ccp_back
  import ccp_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  word_t     in_word,
  ccp_out_if.source cmds
);

  phase_t      phase, phase_next;
  logic        crc_given, crc_given_next;
  logic [7:0]  crc_exp, crc_exp_next;
  logic [7:0]  crc_run, crc_run_next;
  logic [1:0]  hex_seen, hex_seen_next;
  logic [7:0]  letter, letter_next;
  logic        neg, neg_next;
  logic        sign_seen, sign_seen_next;
  logic [3:0]  digit_count, digit_count_next;
  logic [29:0] magnitude, magnitude_next;

  logic        out_valid;
  logic        take;
  logic        emit;
  logic        clr;
  phase_t      clr_phase;
  logic [33:0] mul10;
  logic [30:0] mag_ext;
  logic [30:0] res_value;

  assign in_ready = !out_valid || cmds.ready;
  assign take = in_valid && in_ready;
  assign mul10 = ({4'b0, magnitude} << 3) + ({4'b0, magnitude} << 1)
                 + {30'b0, in_word.ch[3:0]};
  assign mag_ext = {1'b0, magnitude};

  always_comb begin
    if (digit_count == '0) begin
      res_value = '0;
    end else if (neg) begin
      res_value = 31'(-mag_ext);
    end else begin
      res_value = mag_ext;
    end
  end

  always_comb begin
    phase_next = phase;
    crc_given_next = crc_given;
    crc_exp_next = crc_exp;
    crc_run_next = crc_run;
    hex_seen_next = hex_seen;
    letter_next = letter;
    neg_next = neg;
    sign_seen_next = sign_seen;
    digit_count_next = digit_count;
    magnitude_next = magnitude;
    emit = 1'b0;
    clr = 1'b0;
    clr_phase = PH_REJECT;
    if (take) begin
      case (phase)
        PH_WAIT: begin
          if (!in_word.ws) begin
            if (in_word.hex) begin
              crc_given_next = 1'b1;
              crc_exp_next = {4'b0, in_word.hex_val};
              hex_seen_next = 2'd1;
              phase_next = PH_CODE;
            end else begin
              crc_given_next = 1'b0;
              hex_seen_next = 2'd0;
              crc_run_next = crc8_step(8'h00, in_word.ch);
              letter_next = in_word.ch;
              neg_next = 1'b0;
              sign_seen_next = 1'b0;
              digit_count_next = '0;
              magnitude_next = '0;
              phase_next = PH_PARAM;
            end
          end
        end
        PH_CODE: begin
          if (hex_seen == 2'd1) begin
            if (!in_word.hex) begin
              clr = 1'b1;
            end else begin
              crc_exp_next = {crc_exp[3:0], in_word.hex_val};
              hex_seen_next = 2'd2;
            end
          end else if (in_word.ws || in_word.hex) begin
            clr = 1'b1;
          end else begin
            crc_run_next = crc8_step(8'h00, in_word.ch);
            letter_next = in_word.ch;
            neg_next = 1'b0;
            sign_seen_next = 1'b0;
            digit_count_next = '0;
            magnitude_next = '0;
            phase_next = PH_PARAM;
          end
        end
        PH_PARAM: begin
          if (in_word.ws) begin
            clr = 1'b1;
            if (!(crc_given && (crc_run != crc_exp))) begin
              emit = 1'b1;
              clr_phase = PH_WAIT;
            end
          end else if (!sign_seen && (digit_count == '0)
                       && (in_word.plus || in_word.minus)) begin
            sign_seen_next = 1'b1;
            neg_next = in_word.minus;
            crc_run_next = crc8_step(crc_run, in_word.ch);
          end else if (in_word.dec) begin
            if (digit_count >= 4'(MAX_DIGITS)) begin
              clr = 1'b1;
            end else begin
              magnitude_next = mul10[29:0];
              digit_count_next = digit_count + 4'd1;
              crc_run_next = crc8_step(crc_run, in_word.ch);
            end
          end else begin
            clr = 1'b1;
          end
        end
        PH_REJECT: begin
          if (in_word.ws) begin
            clr = 1'b1;
            clr_phase = PH_WAIT;
          end
        end
        default: begin
          clr = 1'b1;
          clr_phase = PH_WAIT;
        end
      endcase
      if (clr) begin
        phase_next = clr_phase;
        crc_given_next = 1'b0;
        crc_exp_next = '0;
        crc_run_next = '0;
        hex_seen_next = '0;
        letter_next = '0;
        neg_next = 1'b0;
        sign_seen_next = 1'b0;
        digit_count_next = '0;
        magnitude_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      crc_given <= 1'b0;
      crc_exp <= '0;
      crc_run <= '0;
      hex_seen <= '0;
      letter <= '0;
      neg <= 1'b0;
      sign_seen <= 1'b0;
      digit_count <= '0;
      magnitude <= '0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      crc_given <= crc_given_next;
      crc_exp <= crc_exp_next;
      crc_run <= crc_run_next;
      hex_seen <= hex_seen_next;
      letter <= letter_next;
      neg <= neg_next;
      sign_seen <= sign_seen_next;
      digit_count <= digit_count_next;
      magnitude <= magnitude_next;
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (cmds.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && emit) begin
      cmds.command_code <= letter;
      cmds.param_value <= res_value;
      cmds.param_present <= (digit_count != '0);
    end
  end

  assign cmds.valid = out_valid;

  a_reset_wait: assert property (@(posedge clk) rst |=> (phase == PH_WAIT) && !out_valid)
    else $error("parser not idle after reset");

  a_result_on_ws: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(take && in_word.ws && (phase == PH_PARAM)))
    else $error("result without closing whitespace");

  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !cmds.param_present) |-> (cmds.param_value == '0))
    else $error("absent parameter with non-zero value");

  a_digit_limit: assert property (@(posedge clk) disable iff (rst)
    digit_count <= 4'(MAX_DIGITS))
    else $error("digit count beyond limit");

  a_code_prefix: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_CODE) |-> (crc_given && (hex_seen != 2'd0)))
    else $error("prefix phase without hex digits");

endmodule
`default_nettype wire

### src/crc_checked_command_parser.sv
// a result is registered: its closing whitespace word passes the queue, then the
// parser loads the result register
// throughput: one word per cycle, set by the parser and crc byte update, except while
// a result waits for the sink; a two-word queue parts the classifier from the parser;
// the result register parts the parser from the sink
// reset: synchronous, clears the queue, the parser state and the result valid
`default_nettype none
module crc_checked_command_parser
  import ccp_pkg::*;
#(
  parameter int MAX_DIGITS = MaxDigitsDefault
) (
  input  logic      clk,
  input  logic      rst,
  ccp_in_if.sink    bytes,
  ccp_out_if.source cmds
);

  word_t front_word;
  logic  front_valid;
  logic  front_ready;
  word_t back_word;
  logic  back_valid;
  logic  back_ready;

  ccp_front u_front (
    .bytes      (bytes),
    .word_valid (front_valid),
    .word_ready (front_ready),
    .word       (front_word)
  );

  ccp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_word  (front_word),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_word   (back_word)
  );

  ccp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (back_valid),
    .in_ready (back_ready),
    .in_word  (back_word),
    .cmds     (cmds)
  );

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ccp_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomWords = 480;
  localparam int CalmWords = 400;

  typedef enum logic [1:0] {
    NO_CRC,
    GOOD_CRC,
    BAD_CRC
  } crc_mode_t;

  typedef struct packed {
    logic [7:0]  code;
    logic [30:0] value;
    logic        present;
  } cmd_t;

  typedef struct packed {
    crc_mode_t  mode;
    logic [7:0] term;
    logic       typed;
    logic       hit;
    cmd_t       want;
  } row_t;

  logic clk;
  logic rst;

  ccp_in_if  byte_link ();
  ccp_out_if cmd_link ();

  crc_checked_command_parser DUT (
    .clk   (clk),
    .rst   (rst),
    .bytes (byte_link),
    .cmds  (cmd_link)
  );

  cmd_t  expected_cmds[$];
  string row_text[$];
  row_t  row_info[$];
  int    errors = 0;
  int    cycles = 0;
  int    items = 0;
  bit    calm = 0;
  bit    quiet = 0;

  phase_t      cmd_phase;
  logic        crc_given;
  logic [7:0]  crc_wanted;
  logic [7:0]  crc_acc;
  logic [1:0]  hex_seen;
  logic [7:0]  letter;
  logic        neg;
  logic        sign_seen;
  logic [3:0]  ndigits;
  logic [29:0] mag;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** crc_checked_command_parser: FAILED **");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] r;
    logic       fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[7] ^ d[i];
      r = {r[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
    end
    return r;
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") v = c - "0";
    else if (c <= "F") v = c - "A" + 8'd10;
    else v = c - "a" + 8'd10;
    return v[3:0];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return "0" + {4'h0, n};
    return (upper ? "A" : "a") + {4'h0, n} - 8'd10;
  endfunction

  function automatic cmd_t cmd_of(input logic [7:0] c, input int v, input bit p);
    cmd_t r;
    r.code = c;
    r.value = v[30:0];
    r.present = p;
    return r;
  endfunction

  task automatic clear_state(input phase_t p);
    cmd_phase = p;
    crc_given = 1'b0;
    crc_wanted = 8'h00;
    crc_acc = 8'h00;
    hex_seen = 2'd0;
    letter = 8'h00;
    neg = 1'b0;
    sign_seen = 1'b0;
    ndigits = 4'd0;
    mag = 30'd0;
  endtask

  task automatic start_letter(input logic [7:0] c);
    crc_acc = crc8_byte(8'h00, c);
    letter = c;
    neg = 1'b0;
    sign_seen = 1'b0;
    ndigits = 4'd0;
    mag = 30'd0;
    cmd_phase = PH_PARAM;
  endtask

  task automatic parse_byte(input logic [7:0] c, output bit hit, output cmd_t res);
    bit          ws;
    logic [30:0] v;
    ws = c <= WsMax;
    hit = 1'b0;
    res = '0;
    case (cmd_phase)
      PH_WAIT: begin
        if (!ws) begin
          if (is_hex(c)) begin
            crc_given = 1'b1;
            crc_wanted = {4'h0, nibble_of(c)};
            hex_seen = 2'd1;
            cmd_phase = PH_CODE;
          end else begin
            start_letter(c);
          end
        end
      end
      PH_CODE: begin
        if (hex_seen == 2'd1) begin
          if (!is_hex(c)) begin
            clear_state(PH_REJECT);
          end else begin
            crc_wanted = {crc_wanted[3:0], nibble_of(c)};
            hex_seen = 2'd2;
          end
        end else if (ws || is_hex(c)) begin
          clear_state(PH_REJECT);
        end else begin
          start_letter(c);
        end
      end
      PH_PARAM: begin
        if (ws) begin
          if (crc_given && crc_acc != crc_wanted) begin
            clear_state(PH_REJECT);
          end else begin
            v = '0;
            if (ndigits != 4'd0) begin
              v = {1'b0, mag};
              if (neg) v = -v;
            end
            hit = 1'b1;
            res.code = letter;
            res.value = v;
            res.present = ndigits != 4'd0;
            clear_state(PH_WAIT);
          end
        end else if (!sign_seen && ndigits == 4'd0 && (c == ChPlus || c == ChMinus)) begin
          sign_seen = 1'b1;
          neg = c == ChMinus;
          crc_acc = crc8_byte(crc_acc, c);
        end else if (is_dec(c)) begin
          if (ndigits >= MaxDigitsDefault) begin
            clear_state(PH_REJECT);
          end else begin
            mag = 30'(mag * 30'd10 + {22'd0, c - "0"});
            ndigits = ndigits + 4'd1;
            crc_acc = crc8_byte(crc_acc, c);
          end
        end else begin
          clear_state(PH_REJECT);
        end
      end
      default: begin
        if (ws) clear_state(PH_WAIT);
      end
    endcase
  endtask

  task report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // drive one word and wait for it to be taken
  task automatic send_byte(input logic [7:0] c, input bit keep);
    bit   hit;
    cmd_t res;
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      byte_link.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    byte_link.valid <= 1'b1;
    byte_link.byte_in <= c;
    @(posedge clk);
    while (!byte_link.ready) @(posedge clk);
    items++;
    parse_byte(c, hit, res);
    if (hit && keep) expected_cmds.push_back(res);
  endtask

  task automatic send_command(input logic [7:0] body[$], input crc_mode_t mode,
                              input logic [7:0] term, input bit keep);
    logic [7:0] sum;
    bit         upper;
    if (mode != NO_CRC) begin
      sum = 8'h00;
      foreach (body[i]) sum = crc8_byte(sum, body[i]);
      if (mode == BAD_CRC) sum ^= 8'($urandom_range(1, 255));
      upper = 1'($urandom_range(0, 1));
      send_byte(hex_char(sum[7:4], upper), keep);
      send_byte(hex_char(sum[3:0], upper), keep);
    end
    foreach (body[i]) send_byte(body[i], keep);
    send_byte(term, keep);
  endtask

  task automatic add_row(input string s, input crc_mode_t m, input logic [7:0] term,
                         input bit typed, input bit hit, input cmd_t w);
    row_t r;
    r.mode = m;
    r.term = term;
    r.typed = typed;
    r.hit = hit;
    r.want = w;
    row_text.push_back(s);
    row_info.push_back(r);
  endtask

  task automatic send_random_token();
    logic [7:0] body[$];
    logic [7:0] c;
    crc_mode_t  mode;
    int         kind;
    int         flaw;
    int         ndig;
    kind = $urandom_range(0, 9);
    flaw = $urandom_range(0, 4);
    quiet = $urandom_range(0, 4) == 0;
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b1);
      return;
    end
    do c = 8'($urandom_range(33, 255)); while (is_hex(c));
    body.push_back(c);
    case ($urandom_range(0, 2))
      1: body.push_back(ChPlus);
      2: body.push_back(ChMinus);
      default: ;
    endcase
    ndig = $urandom_range(0, 9);
    mode = $urandom_range(0, 1) ? GOOD_CRC : NO_CRC;
    if (kind <= 2) begin
      case (flaw)
        0: mode = BAD_CRC;
        1: ndig = MaxDigitsDefault + 1;
        3: body.push_back($urandom_range(0, 1) ? ChPlus : ChMinus);
        default: ;
      endcase
    end
    repeat (ndig) body.push_back("0" + 8'($urandom_range(0, 9)));
    if (kind <= 2 && flaw == 2)
      body.insert($urandom_range(0, body.size()), 8'($urandom_range(0, 255)));
    if (kind <= 2 && flaw == 4) begin
      mode = NO_CRC;
      body.push_front(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    send_command(body, mode, 8'($urandom_range(0, 32)), 1'b1);
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom_range(0, 32)), 1'b1);
  endtask

  initial begin
    cmd_link.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        cmd_link.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      cmd_link.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    if (!rst && cmd_link.valid && cmd_link.ready) begin
      if (expected_cmds.size() == 0) begin
        report($sformatf("unexpected command code %02h", cmd_link.command_code));
      end else begin
        want = expected_cmds.pop_front();
        if (cmd_link.command_code !== want.code)
          report($sformatf("command_code %02h, want %02h", cmd_link.command_code, want.code));
        if (cmd_link.param_value !== want.value)
          report($sformatf("param_value %0d, want %0d", $signed(cmd_link.param_value),
                           $signed(want.value)));
        if (cmd_link.param_present !== want.present)
          report($sformatf("param_present %0b, want %0b", cmd_link.param_present,
                           want.present));
      end
    end
  end

  initial begin
    logic [7:0] body[$];
    int         base;
    int         waited;
    rst <= 1'b1;
    byte_link.valid <= 1'b0;
    byte_link.byte_in <= 8'h00;
    clear_state(PH_WAIT);

    add_row("K",           NO_CRC,   " ",   1, 1, cmd_of("K", 0, 0));
    add_row("!",           NO_CRC,   " ",   1, 1, cmd_of("!", 0, 0));
    add_row("Z999999999",  NO_CRC,   " ",   1, 1, cmd_of("Z", 999999999, 1));
    add_row("z-999999999", NO_CRC,   " ",   1, 1, cmd_of("z", -999999999, 1));
    add_row("q1234567890", NO_CRC,   " ",   1, 0, '0);
    add_row("\377+",       NO_CRC,   8'h00, 1, 1, cmd_of(8'hff, 0, 0));
    add_row("Q-0",         NO_CRC,   " ",   1, 1, cmd_of("Q", 0, 1));
    add_row("+5",          NO_CRC,   " ",   1, 1, cmd_of("+", 5, 1));
    add_row("B+-3",        NO_CRC,   " ",   1, 0, '0);
    add_row("P5+",         NO_CRC,   " ",   1, 0, '0);
    add_row("H1x",         NO_CRC,   " ",   1, 0, '0);
    add_row("T7",          NO_CRC,   8'h09, 1, 1, cmd_of("T", 7, 1));
    add_row("M+42",        GOOD_CRC, " ",   0, 0, '0);
    add_row("k-7",         GOOD_CRC, " ",   0, 0, '0);
    add_row("\200-1",      GOOD_CRC, " ",   0, 0, '0);
    add_row("++1",         GOOD_CRC, " ",   0, 0, '0);
    add_row("N",           BAD_CRC,  " ",   0, 0, '0);
    add_row("F1",          NO_CRC,   " ",   0, 0, '0);
    add_row("7",           NO_CRC,   " ",   0, 0, '0);
    add_row("G",           NO_CRC,   " ",   0, 0, '0);
    add_row("4g",          NO_CRC,   " ",   0, 0, '0);
    add_row("3A",          NO_CRC,   " ",   0, 0, '0);
    add_row("R",           NO_CRC,   " ",   0, 0, '0);
    add_row("3AB",         NO_CRC,   " ",   0, 0, '0);
    add_row("x12",         GOOD_CRC, 8'h20, 0, 0, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (row_text[i]) begin
      body.delete();
      for (int j = 0; j < row_text[i].len(); j++) body.push_back(row_text[i][j]);
      send_command(body, row_info[i].mode, row_info[i].term, !row_info[i].typed);
      if (row_info[i].typed && row_info[i].hit) expected_cmds.push_back(row_info[i].want);
    end

    base = items;
    while (items - base < RandomWords) begin
      if (items - base >= CalmWords) calm = 1'b1;
      send_random_token();
    end
    byte_link.valid <= 1'b0;

    waited = 0;
    while (expected_cmds.size() != 0 && waited < 4000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_cmds.size() != 0)
      report($sformatf("%0d commands never arrived", expected_cmds.size()));
    repeat (5) @(posedge clk);

    if (errors == 0) begin
      $display("** crc_checked_command_parser: PASSED **");
    end else begin
      $display("** crc_checked_command_parser: FAILED **");
    end
    $finish;
  end

endmodule
